@@ hdl/slcd_pkg.sv @@
// slcd_pkg: shared types and constants for the sync length checksum deframer
// used by slcd_core, slcd_obuf and sync_length_checksum_deframer_unit
`default_nettype none

package slcd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgAddrW = 2;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_SKIP_LIMIT  = 2'd2;

  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hFA;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'hFB;
  localparam logic [ByteW-1:0] SKIP_LIMIT_RST  = 8'd200;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_CHECK   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_LOST = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic [ByteW-1:0] calc_sum;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } obuf_sts_t;

endpackage

`default_nettype wire

@@ hdl/slcd_core.sv @@
// slcd_core: input register, configuration registers and deframer state
// one byte is decoded per cycle while the result buffer is not full, into at most one result; depends on slcd_pkg
`default_nettype none

module slcd_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slcd_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [slcd_pkg::ByteW-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [slcd_pkg::ByteW-1:0]      in_rx_byte,
  input  logic                            buf_full,
  output logic                            res_valid,
  output slcd_pkg::res_t                  res
);
  import slcd_pkg::*;

  logic             stg_valid_r;
  logic [ByteW-1:0] stg_byte_r;

  logic [ByteW-1:0] sync_first_r;
  logic [ByteW-1:0] sync_second_r;
  logic [ByteW-1:0] skip_limit_r;

  phase_t           phase_r, phase_nxt;
  logic [ByteW-1:0] hist_old_r, hist_old_nxt;
  logic [ByteW-1:0] hist_new_r, hist_new_nxt;
  logic [ByteW-1:0] remaining_r, remaining_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;
  logic [ByteW-1:0] skip_cnt_r, skip_cnt_nxt;

  logic             fire;
  logic             sync_hit;
  logic             skip_over;
  logic [ByteW-1:0] rem_dec;
  logic [ByteW-1:0] sum_add;

  assign fire      = stg_valid_r && !buf_full;
  assign in_ready  = !stg_valid_r || fire;
  assign sync_hit  = (hist_old_r == sync_first_r) && (hist_new_r == sync_second_r);
  assign skip_over = skip_cnt_r >= skip_limit_r;
  assign rem_dec   = remaining_r - 8'd1;
  assign sum_add   = sum_r + stg_byte_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stg_valid_r <= 1'b1;
    end else if (fire) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_byte_r <= in_rx_byte;
    end
  end

  // configuration registers, index 3 ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      skip_limit_r  <= SKIP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        REG_SKIP_LIMIT:  skip_limit_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    hist_old_nxt  = hist_old_r;
    hist_new_nxt  = hist_new_r;
    remaining_nxt = remaining_r;
    sum_nxt       = sum_r;
    skip_cnt_nxt  = skip_cnt_r;
    unique case (phase_r)
      PH_PAYLOAD: begin
        sum_nxt       = sum_add;
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // frame done, start a new hunt
        phase_nxt    = PH_HUNT;
        hist_old_nxt = '0;
        hist_new_nxt = '0;
        skip_cnt_nxt = '0;
      end
      default: begin
        if (sync_hit) begin
          // this byte is the length
          sum_nxt       = stg_byte_r;
          remaining_nxt = stg_byte_r;
          phase_nxt     = (stg_byte_r == '0) ? PH_CHECK : PH_PAYLOAD;
        end else begin
          phase_nxt = PH_HUNT;
          if (skip_over) begin
            hist_old_nxt = '0;
            hist_new_nxt = '0;
            skip_cnt_nxt = '0;
          end else begin
            hist_old_nxt = hist_new_r;
            hist_new_nxt = stg_byte_r;
            skip_cnt_nxt = skip_cnt_r + 8'd1;
          end
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    res_valid    = 1'b0;
    res.kind     = KIND_DATA;
    res.data     = stg_byte_r;
    res.calc_sum = '0;
    unique case (phase_r)
      PH_PAYLOAD: begin
        res_valid = fire;
      end
      PH_CHECK: begin
        res_valid    = fire;
        res.kind     = (stg_byte_r == sum_r) ? KIND_GOOD : KIND_BAD;
        res.calc_sum = sum_r;
      end
      default: begin
        res_valid = fire && !sync_hit && skip_over;
        res.kind  = KIND_LOST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      hist_old_r  <= '0;
      hist_new_r  <= '0;
      remaining_r <= '0;
      sum_r       <= '0;
      skip_cnt_r  <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      hist_old_r  <= hist_old_nxt;
      hist_new_r  <= hist_new_nxt;
      remaining_r <= remaining_nxt;
      sum_r       <= sum_nxt;
      skip_cnt_r  <= skip_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/slcd_obuf.sv @@
// slcd_obuf: two-entry result buffer between the decoder and the out channel
// keeps the decoder running while a result waits; depends on slcd_pkg
`default_nettype none

module slcd_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  slcd_pkg::res_t        push_res,
  output slcd_pkg::obuf_sts_t   sts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output slcd_pkg::res_t        out_res
);
  import slcd_pkg::*;

  res_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;
  logic       do_push;

  assign sts.full  = count_r == 2'd2;
  assign sts.empty = count_r == 2'd0;
  assign out_valid = !sts.empty;
  assign out_res   = ent_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign do_push   = push && !sts.full;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_res;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sync_length_checksum_deframer_unit.sv @@
// datapath: a byte is registered in the input register, decoded from there, and its
// result is written into the result buffer, which offers it on the out channel
// throughput: one byte per cycle while the result buffer is not full, set by the
// single decode stage and the two-entry result buffer; bytes that cause no result still use the decode stage
// reset: synchronous active-low rst_n restores config defaults and hunting
`default_nettype none

module sync_length_checksum_deframer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [slcd_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [slcd_pkg::ByteW-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [slcd_pkg::ByteW-1:0]      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_kind,
  output logic [slcd_pkg::ByteW-1:0]      out_data,
  output logic [slcd_pkg::ByteW-1:0]      out_calc_sum
);
  import slcd_pkg::*;

  logic      res_valid;
  res_t      res;
  res_t      out_res;
  obuf_sts_t buf_sts;

  slcd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .buf_full   (buf_sts.full),
    .res_valid  (res_valid),
    .res        (res)
  );

  slcd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .sts       (buf_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind     = out_res.kind;
  assign out_data     = out_res.data;
  assign out_calc_sum = out_res.calc_sum;

`ifndef SYNTHESIS
  a_reset_clears_out : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> buf_sts.full)
    else $error("input stalled while result buffer has room");

  a_full_means_valid : assert property (@(posedge clk) disable iff (!rst_n)
    buf_sts.full |-> out_valid)
    else $error("result buffer full but nothing offered");

  a_data_sum_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_DATA || out_kind == KIND_LOST)) |->
      out_calc_sum == '0)
    else $error("nonzero sum on payload or sync lost result");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// testbench for sync_length_checksum_deframer_unit: drives received bytes on the in channel,
// predicts frame results in a small tracker class and checks each out transaction
// depends on slcd_pkg and the deframer RTL only
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slcd_pkg::*;

  localparam logic [CfgAddrW-1:0] REG_UNUSED = 2'd3;  // index with no register behind it
  localparam int NUM_SETTINGS = 8;
  localparam int BYTES_PER_SETTING = 210;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RUN_LIMIT_NS = 3_000_000;

  typedef enum int {FRAME_GOOD, FRAME_BAD, FRAME_CUT} frame_mode_t;

  // mirrors the deframer state and queues the results it owes
  class deframe_tracker;
    logic [ByteW-1:0] sync_a, sync_b, skip_lim;
    logic [ByteW-1:0] hist_old, hist_new, remaining, sum, skips;
    phase_t phase;
    res_t awaited[$];
    int failures;
    int seen[4];

    function new();
      sync_a = SYNC_FIRST_RST;
      sync_b = SYNC_SECOND_RST;
      skip_lim = SKIP_LIMIT_RST;
      remaining = '0;
      sum = '0;
      failures = 0;
      foreach (seen[i]) seen[i] = 0;
      restart_hunt();
    endfunction

    function void restart_hunt();
      hist_old = '0;
      hist_new = '0;
      skips = '0;
      phase = PH_HUNT;
    endfunction

    function void write_reg(logic [CfgAddrW-1:0] idx, logic [ByteW-1:0] val);
      case (idx)
        REG_SYNC_FIRST:  sync_a = val;
        REG_SYNC_SECOND: sync_b = val;
        REG_SKIP_LIMIT:  skip_lim = val;
        default: ;
      endcase
    endfunction

    // one accepted rx byte: advance the frame state, queue a result if one is due
    function void take_rx_byte(logic [ByteW-1:0] b);
      res_t r;
      r.kind = KIND_DATA;
      r.data = b;
      r.calc_sum = '0;
      case (phase)
        PH_PAYLOAD: begin
          sum = sum + b;
          remaining = remaining - 8'd1;
          if (remaining == 0) phase = PH_CHECK;
          awaited.push_back(r);
        end
        PH_CHECK: begin
          r.kind = (b == sum) ? KIND_GOOD : KIND_BAD;
          r.calc_sum = sum;
          awaited.push_back(r);
          restart_hunt();
        end
        default: begin
          if (hist_old == sync_a && hist_new == sync_b) begin
            // length byte
            sum = b;
            remaining = b;
            phase = (b == 0) ? PH_CHECK : PH_PAYLOAD;
          end else begin
            hist_old = hist_new;
            hist_new = b;
            phase = PH_HUNT;
            if (skips >= skip_lim) begin
              restart_hunt();
              r.kind = KIND_LOST;
              awaited.push_back(r);
            end else begin
              skips = skips + 8'd1;
            end
          end
        end
      endcase
    endfunction

    function void check_output(kind_t kind, logic [ByteW-1:0] data, logic [ByteW-1:0] csum);
      res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: kind %0d data 0x%02h calc_sum 0x%02h", kind, data, csum);
        failures++;
        return;
      end
      want = awaited.pop_front();
      seen[want.kind]++;
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        failures++;
      end
      if (data !== want.data) begin
        $error("data: expected 0x%02h, actual 0x%02h", want.data, data);
        failures++;
      end
      if (csum !== want.calc_sum) begin
        $error("calc_sum: expected 0x%02h, actual 0x%02h", want.calc_sum, csum);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [ByteW-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [ByteW-1:0] in_rx_byte;
  logic out_valid;
  logic out_ready;
  logic [1:0] out_kind;
  logic [ByteW-1:0] out_data;
  logic [ByteW-1:0] out_calc_sum;

  deframe_tracker tracker;
  int rx_bytes_sent = 0;
  int gap_pct = 0;
  int hold_off_req = 0;
  bit quiet = 1'b0;

  sync_length_checksum_deframer_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_data     (out_data),
    .out_calc_sum (out_calc_sum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // receiver side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_req) @(posedge clk);
        hold_off_req = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_output(kind_t'(out_kind), out_data, out_calc_sum);
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.take_rx_byte(b);
    rx_bytes_sent++;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_frame(input int noise, input int len, input frame_mode_t mode);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] b;
    int body;
    send_noise(noise);
    // a 0,0 pair already sits in the cleared history
    if (tracker.sync_a != 0 || tracker.sync_b != 0) begin
      send_byte(tracker.sync_a);
      send_byte(tracker.sync_b);
    end
    acc = 8'(len);
    send_byte(acc);
    body = (mode == FRAME_CUT) ? len / 2 : len;
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom_range(0, 255));
      acc = acc + b;
      send_byte(b);
    end
    if (mode == FRAME_GOOD)
      send_byte(acc);
    else if (mode == FRAME_BAD)
      send_byte(acc ^ 8'($urandom_range(1, 255)));
  endtask

  // sender pauses until every result is back, then lets the pipeline settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] default_pair_bytes [16];
    logic [ByteW-1:0] zero_pair_bytes [7];
    logic [ByteW-1:0] first_val, second_val, limit_val;
    int setting_end;
    int pick;
    int len;
    frame_mode_t mode;

    tracker = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= REG_SYNC_FIRST;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset pair: a skipped byte, payload 00/ff with wrapping sum, a bad checksum,
    // a zero-length frame
    default_pair_bytes = '{8'h11, 8'hFA, 8'hFB, 8'h02, 8'h00, 8'hFF, 8'h01,
                           8'hFA, 8'hFB, 8'h01, 8'h80, 8'h00,
                           8'hFA, 8'hFB, 8'h00, 8'h00};
    foreach (default_pair_bytes[i]) send_byte(default_pair_bytes[i]);
    wait_for_results();

    // skip limit zero: each hunted byte loses sync
    write_reg(REG_SKIP_LIMIT, 8'd0);
    send_byte(8'h12);
    send_byte(8'h34);
    wait_for_results();

    // 0,0 pair matches at once after every hunt restart; the unused index is ignored
    write_reg(REG_SYNC_FIRST, 8'h00);
    write_reg(REG_SYNC_SECOND, 8'h00);
    write_reg(REG_UNUSED, 8'hFF);
    zero_pair_bytes = '{8'h00, 8'h00, 8'h03, 8'hAA, 8'h55, 8'h01, 8'h03};
    foreach (zero_pair_bytes[i]) send_byte(zero_pair_bytes[i]);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      wait_for_results();
      first_val = 8'($urandom_range(0, 255));
      second_val = 8'($urandom_range(0, 255));
      limit_val = 8'($urandom_range(0, 255));
      case (s)
        0, 1: limit_val = 8'd255;
        2: begin
          first_val = 8'h00;
          second_val = 8'h00;
        end
        3: begin
          first_val = 8'hFF;
          second_val = 8'hFF;
          limit_val = 8'd2;
        end
        4: limit_val = 8'd0;
        5: limit_val = 8'($urandom_range(2, 20));
        6: begin
          first_val = SYNC_FIRST_RST;
          second_val = SYNC_SECOND_RST;
          limit_val = SKIP_LIMIT_RST;
        end
        default: ;
      endcase
      write_reg(REG_SYNC_FIRST, first_val);
      write_reg(REG_SYNC_SECOND, second_val);
      write_reg(REG_SKIP_LIMIT, limit_val);
      if ($urandom_range(0, 1) == 1) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));

      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 40;
      endcase
      if (s == NUM_SETTINGS - 1) quiet = 1'b1;
      setting_end = rx_bytes_sent + BYTES_PER_SETTING;

      // long hunt that runs past the largest skip limit
      if (s == 0) send_noise(260);
      // receiver holds off while a long frame backs up into the input
      if (s == 1) begin
        hold_off_req = HOLD_OFF_CYCLES;
        send_frame(0, 40, FRAME_GOOD);
      end

      while (rx_bytes_sent < setting_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = ($urandom_range(0, 59) == 0) ? $urandom_range(13, 255) : $urandom_range(0, 12);
          pick = $urandom_range(0, 99);
          mode = (pick < 80) ? FRAME_GOOD : (pick < 95) ? FRAME_BAD : FRAME_CUT;
          send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0, len, mode);
        end else if (pick < 85) begin
          send_noise($urandom_range(1, 10));
        end else begin
          // partial sync pair followed by junk
          send_byte(tracker.sync_a);
          if ($urandom_range(0, 1) == 1) send_byte(tracker.sync_b ^ 8'($urandom_range(1, 255)));
          send_noise($urandom_range(0, 2));
        end
      end
    end

    wait_for_results();
    $display("sent %0d rx bytes across %0d register settings", rx_bytes_sent, NUM_SETTINGS + 3);
    $display("checked %0d payload bytes, %0d good frames, %0d bad checksums, %0d sync losses",
             tracker.seen[KIND_DATA], tracker.seen[KIND_GOOD], tracker.seen[KIND_BAD],
             tracker.seen[KIND_LOST]);
    if (tracker.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sync_length_checksum_deframer_unit.f @@
hdl/slcd_pkg.sv
hdl/slcd_core.sv
hdl/slcd_obuf.sv
hdl/sync_length_checksum_deframer_unit.sv
dv/testbench.sv
